>>> design/lrst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrst_pkg: shared types and constants for the range add / range sum block
// Field widths, controller states, datapath operations and status bundle.
// ----------------------------------------------------------------------------
package lrst_pkg;

  localparam int NumElementsDef = 1024;
  localparam int LeftW          = 10;
  localparam int RightW         = 11;
  localparam int ValueW         = 32;
  localparam int SumW           = 64;

  typedef enum logic [0:0] {
    ACT_ADD = 1'b0,
    ACT_SUM = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_USET,
    ST_URD,
    ST_UWR,
    ST_QSET,
    ST_QRD,
    ST_QACC,
    ST_QMUL,
    ST_QFIN,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_USETUP,
    OP_URD,
    OP_UWR,
    OP_PHASE,
    OP_QSETUP,
    OP_QRD,
    OP_QACC,
    OP_QMUL,
    OP_QFIN,
    OP_ZERO,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    logic empty;
    logic is_sum;
    logic phase;
    logic p_zero;
    logic p_over;
    logic clr_last;
  } dp_status_t;

endpackage
`default_nettype wire

>>> design/lrst_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrst_if: request and result channel interfaces
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lrst_in_if;
  import lrst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [LeftW-1:0]         left;
  logic [RightW-1:0]        right_end;
  logic signed [ValueW-1:0] value;

  modport source (output valid, action, left, right_end, value, input ready);
  modport sink   (input valid, action, left, right_end, value, output ready);
endinterface

interface lrst_out_if;
  import lrst_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SumW-1:0] range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink   (input valid, range_sum, output ready);
endinterface
`default_nettype wire

>>> design/lrst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrst_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lrst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/lrst_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrst_dp: datapath of the range add / range sum block
// Two Fenwick trees (per-element delta and index-weighted delta) share one
// RAM row; holds the walk pointer, accumulators, multiplier and result.
// ----------------------------------------------------------------------------
module lrst_dp import lrst_pkg::*; #(
  parameter int NUM_ELEMENTS = NumElementsDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dp_op_t                   op,
  input  wire logic                     in_action,
  input  wire logic [LeftW-1:0]         in_left,
  input  wire logic [RightW-1:0]        in_right_end,
  input  wire logic signed [ValueW-1:0] in_value,
  output logic [SumW-1:0]               out_data,
  output dp_status_t                    status
);

  localparam int AW = $clog2(NUM_ELEMENTS);
  localparam int PW = AW + 2;
  localparam int DW = 2 * SumW;
  localparam logic [PW-1:0] NP = PW'(NUM_ELEMENTS);

  logic          is_sum_r, phase_r;
  logic [PW-1:0] lo_r, hi_r, p_r, point_r;
  logic [SumW-1:0] v_r, d1_r, d2_r, acc1_r, acc2_r, prod_r, pref_r, res_r, out_r;
  logic [AW-1:0] clr_r;

  logic [31:0]     left32, right32, lo_c, hi_c;
  logic [PW-1:0]   upoint, qpoint, lowbit, pm1;
  logic [SumW-1:0] vneg, umul, qmul, cur_pref;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [DW-1:0]   wdata, rdata;

  always_comb begin
    left32  = 32'(in_left);
    right32 = 32'(in_right_end);
    lo_c    = (left32 > 32'(NUM_ELEMENTS)) ? 32'(NUM_ELEMENTS) : left32;
    hi_c    = (right32 > 32'(NUM_ELEMENTS)) ? 32'(NUM_ELEMENTS) : right32;
    upoint  = phase_r ? hi_r : lo_r;
    qpoint  = phase_r ? lo_r : hi_r;
    lowbit  = p_r & (~p_r + PW'(1));
    pm1     = p_r - PW'(1);
    vneg    = phase_r ? (~v_r + SumW'(1)) : v_r;
    umul    = vneg * {{(SumW-PW){1'b0}}, upoint};
    qmul    = acc1_r * {{(SumW-PW){1'b0}}, point_r};
    cur_pref = prod_r - acc2_r;
    we      = (op == OP_CLEAR) || (op == OP_UWR);
    waddr   = (op == OP_CLEAR) ? clr_r : pm1[AW-1:0];
    wdata   = (op == OP_CLEAR) ? '0 :
              {rdata[DW-1:SumW] + d1_r, rdata[SumW-1:0] + d2_r};
  end

  lrst_ram #(.WIDTH(DW), .DEPTH(NUM_ELEMENTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pm1[AW-1:0]),
    .rdata (rdata)
  );

  // sweep counter for the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (op == OP_CLEAR) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        is_sum_r <= in_action;
        lo_r     <= lo_c[PW-1:0];
        hi_r     <= hi_c[PW-1:0];
        v_r      <= SumW'(in_value);
        phase_r  <= 1'b0;
      end
      OP_USETUP: begin
        p_r  <= upoint + PW'(1);
        d1_r <= vneg;
        d2_r <= umul;
      end
      OP_UWR: p_r <= p_r + lowbit;
      OP_PHASE: phase_r <= 1'b1;
      OP_QSETUP: begin
        p_r     <= qpoint;
        point_r <= qpoint;
        acc1_r  <= '0;
        acc2_r  <= '0;
      end
      OP_QACC: begin
        acc1_r <= acc1_r + rdata[DW-1:SumW];
        acc2_r <= acc2_r + rdata[SumW-1:0];
        p_r    <= p_r - lowbit;
      end
      OP_QMUL: prod_r <= qmul;
      OP_QFIN: begin
        if (!phase_r) begin
          pref_r  <= cur_pref;
          phase_r <= 1'b1;
        end else begin
          res_r <= pref_r - cur_pref;
        end
      end
      OP_ZERO: res_r <= '0;
      OP_PUBLISH: out_r <= res_r;
      default: ;
    endcase
  end

  assign out_data        = out_r;
  assign status.empty    = (lo_r >= hi_r);
  assign status.is_sum   = is_sum_r;
  assign status.phase    = phase_r;
  assign status.p_zero   = (p_r == '0);
  assign status.p_over   = (p_r > NP);
  assign status.clr_last = (clr_r == AW'(NUM_ELEMENTS - 1));

endmodule
`default_nettype wire

>>> design/lrst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrst_ctrl: controller of the range add / range sum block
// Sequences clearing, tree walks and result hand-off; owns the handshakes.
// ----------------------------------------------------------------------------
module lrst_ctrl import lrst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_op_t          op
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op            = OP_NONE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        op = OP_CLEAR;
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.empty) begin
          if (status.is_sum) begin
            op        = OP_ZERO;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = status.is_sum ? ST_QSET : ST_USET;
        end
      end
      ST_USET: begin
        op        = OP_USETUP;
        state_nxt = ST_URD;
      end
      ST_URD: begin
        if (status.p_over) begin
          if (status.phase) begin
            state_nxt = ST_IDLE;
          end else begin
            op        = OP_PHASE;
            state_nxt = ST_USET;
          end
        end else begin
          op        = OP_URD;
          state_nxt = ST_UWR;
        end
      end
      ST_UWR: begin
        op        = OP_UWR;
        state_nxt = ST_URD;
      end
      ST_QSET: begin
        op        = OP_QSETUP;
        state_nxt = ST_QRD;
      end
      ST_QRD: begin
        if (status.p_zero) begin
          state_nxt = ST_QMUL;
        end else begin
          op        = OP_QRD;
          state_nxt = ST_QACC;
        end
      end
      ST_QACC: begin
        op        = OP_QACC;
        state_nxt = ST_QRD;
      end
      ST_QMUL: begin
        op        = OP_QMUL;
        state_nxt = ST_QFIN;
      end
      ST_QFIN: begin
        op        = OP_QFIN;
        state_nxt = status.phase ? ST_OUT : ST_QSET;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          op            = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> design/lazy_range_add_range_sum_tree.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lazy_range_add_range_sum_tree: range add / range sum over NUM_ELEMENTS
// Request channel in_ch carries action (0 add, 1 sum), left, right_end and
// value; the range is [left, right_end), both ends clamped to NUM_ELEMENTS.
// An add request gives no result; a sum request gives one range_sum on out_ch
// (zero for an empty range). All sums wrap modulo 2^64.
// Internally two Fenwick trees share one RAM row (delta and index * delta),
// so a prefix sum at p is B1(p) * p - B2(p).
// An add walks the Fenwick steps up from each boundary, lo and then hi,
// reading and then writing the RAM row at each step; in_ch.ready stays
// low until both walks are done. A sum walks down from the clamped
// right_end and then from the clamped left, summing both trees, and
// forms each prefix with a multiply before out_ch.valid is raised.
// One request is in work at a time; in_ch.ready is high only when idle.
// After reset the RAM is cleared, one row a cycle, with in_ch.ready low.
// A result waits in an output register: the next request is accepted
// while it is held, and a finished sum stalls only until out_ch.ready
// takes the previous one.
// ----------------------------------------------------------------------------
module lazy_range_add_range_sum_tree import lrst_pkg::*; #(
  parameter int NUM_ELEMENTS = NumElementsDef
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lrst_in_if.sink     in_ch,
  lrst_out_if.source  out_ch
);

  dp_op_t          op;
  dp_status_t      status;
  logic [SumW-1:0] sum_data;

  // sequence the walks and own both handshakes
  lrst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .op        (op)
  );

  // hold the request, walk the trees, build the result
  lrst_dp #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .in_action    (in_ch.action),
    .in_left      (in_ch.left),
    .in_right_end (in_ch.right_end),
    .in_value     (in_ch.value),
    .out_data     (sum_data),
    .status       (status)
  );

  assign out_ch.range_sum = sum_data;

endmodule
`default_nettype wire

>>> design/lrst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrst_checker: port-level checks for the range add / range sum block
// Watches the handshakes and the result timing; bound to the top level.
// ----------------------------------------------------------------------------
module lrst_checker import lrst_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [SumW-1:0] range_sum
);

  // one request at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in work");

  // no result appears the cycle after a request is taken
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(range_sum))
    else $error("result changed while stalled");

endmodule

bind lazy_range_add_range_sum_tree lrst_checker u_lrst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .range_sum (out_ch.range_sum)
);
`default_nettype wire

>>> tb/lrst_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrst_tb_if: testbench note
// The block's channel interfaces come from design/lrst_if.sv; nothing is
// redefined here. This file only holds a small helper package of request
// types used by the testbench top.
// ----------------------------------------------------------------------------
package lrst_tb_pkg;
  import lrst_pkg::*;

  typedef struct {
    action_t                  action;
    logic [LeftW-1:0]         left;
    logic [RightW-1:0]        right_end;
    logic signed [ValueW-1:0] value;
  } tree_req_t;
endpackage

>>> tb/lazy_range_add_range_sum_tree_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_range_add_range_sum_tree_tb: self-checking bench for range add / sum
// Drives add and sum requests through valid/ready, keeps a flat element
// array as the predictor and checks every range_sum in order.
// ----------------------------------------------------------------------------
module lazy_range_add_range_sum_tree_tb;
  import lrst_pkg::*;
  import lrst_tb_pkg::*;

  localparam int NumEl = NumElementsDef;

  // Flat-array predictor plus a queue of pending sums.
  class sum_board;
    logic [SumW-1:0] elem[NumEl];
    logic [SumW-1:0] sum_q[$];
    int              errors;

    function void clear();
      foreach (elem[i]) elem[i] = '0;
      sum_q.delete();
      errors = 0;
    endfunction

    function void note_request(tree_req_t r);
      int lo;
      int hi;
      logic [SumW-1:0] acc;
      lo = (r.left > NumEl) ? NumEl : int'(r.left);
      hi = (r.right_end > NumEl) ? NumEl : int'(r.right_end);
      acc = '0;
      if (r.action == ACT_ADD) begin
        for (int i = lo; i < hi; i++) elem[i] += {{32{r.value[31]}}, r.value};
      end else begin
        for (int i = lo; i < hi; i++) acc += elem[i];
        sum_q.push_back(acc);
      end
    endfunction

    function void check_sum(logic [SumW-1:0] got);
      logic [SumW-1:0] want;
      if (sum_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected range_sum %0h", got);
        return;
      end
      want = sum_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("range_sum mismatch: expected %0h got %0h", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   src_idle = 24;
  int   snk_idle = 72;
  bit   done = 1'b0;
  sum_board board;

  lrst_in_if  in_ch();
  lrst_out_if out_ch();

  lazy_range_add_range_sum_tree i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  initial begin
    board = new();
    board.clear();
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ADD;
    in_ch.left = '0;
    in_ch.right_end = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
  end

  // Randomly stall the result side; check on accepted results.
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= snk_idle);
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_sum(out_ch.range_sum);
  end

  // Idle a while, present one request, hold until accepted, then note it.
  task automatic send_request(action_t a, int lo, int hi, int v);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= a;
    in_ch.left <= lo[LeftW-1:0];
    in_ch.right_end <= hi[RightW-1:0];
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request('{a, lo[LeftW-1:0], hi[RightW-1:0], v});
    @(negedge clk);
  endtask

  // Mostly small ranges, with a few wide and out-of-bound ones.
  task automatic random_request();
    int lo;
    int hi;
    action_t a;
    a = action_t'($urandom_range(1));
    lo = $urandom_range(NumEl - 1);
    case ($urandom_range(9))
      0: hi = $urandom_range(2047);
      1: hi = $urandom_range(lo);
      2: hi = NumEl;
      default: hi = lo + $urandom_range(40);
    endcase
    send_request(a, lo, hi, $urandom());
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    // Directed: extremes, empty ranges, ranges past the end.
    send_request(ACT_SUM, 0, NumEl, 0);
    send_request(ACT_ADD, 0, NumEl, 32'h7fffffff);
    send_request(ACT_ADD, 0, 1, 32'h80000000);
    send_request(ACT_ADD, NumEl - 1, 2047, -1);
    send_request(ACT_ADD, 5, 5, 123);
    send_request(ACT_ADD, 9, 3, 77);
    send_request(ACT_SUM, 0, NumEl, 0);
    send_request(ACT_SUM, 0, 1, -1);
    send_request(ACT_SUM, NumEl - 1, 2047, 0);
    send_request(ACT_SUM, 7, 7, 0);
    send_request(ACT_SUM, 500, 3, 0);
    send_request(ACT_ADD, 3, 700, 32'h55555555);
    send_request(ACT_ADD, 511, 513, 32'haaaaaaaa);
    send_request(ACT_SUM, 1, 1023, 0);
    send_request(ACT_SUM, 512, 513, 0);
    send_request(ACT_SUM, 0, 2047, 0);
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 24 : (ph == 1) ? 72 : 0;
      snk_idle = (ph == 0) ? 72 : (ph == 1) ? 24 : 0;
      repeat (145) random_request();
    end
    in_ch.valid <= 1'b0;
    while (board.sum_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    done = 1'b1;
    if (board.errors == 0) begin
      $display("** lazy_range_add_range_sum_tree: PASSED **");
    end else begin
      $display("** lazy_range_add_range_sum_tree: FAILED **");
    end
    $finish;
  end

  // Timeout: clear pass plus generous per-request budget.
  initial begin
    #5ms;
    if (!done) begin
      $display("** lazy_range_add_range_sum_tree: FAILED **");
      $finish;
    end
  end
endmodule
